>>> sv/orl_pkg.sv
// shared types and constants for the ordered record list
`timescale 1ns / 1ps

package orl_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FLD_W = 16;

    localparam logic [2:0] MODE_CLEAR     = 3'd0;
    localparam logic [2:0] MODE_INSERT    = 3'd1;
    localparam logic [2:0] MODE_APPEND    = 3'd2;
    localparam logic [2:0] MODE_OVERWRITE = 3'd3;
    localparam logic [2:0] MODE_DELETE    = 3'd4;
    localparam logic [2:0] MODE_SEARCH    = 3'd5;
    localparam logic [2:0] MODE_READ      = 3'd6;
    localparam logic [2:0] MODE_PURGE     = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [FLD_W-1:0] id;
        logic [FLD_W-1:0] duration;
        logic [FLD_W-1:0] price;
        logic [FLD_W-1:0] durability;
    } orl_rec_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } orl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_op;
        logic scan_done;
    } orl_stat_t;

endpackage

>>> sv/orl_ctrl.sv
// controller state machine: handshakes and scan sequencing
`timescale 1ns / 1ps

module orl_ctrl import orl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  orl_stat_t stat,
    output orl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.scan_op && !stat.scan_done) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> sv/orl_datapath.sv
// datapath: record shift chain, count, scan pointer and result registers
`timescale 1ns / 1ps

module orl_datapath import orl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  orl_cmd_t         cmd,
    output orl_stat_t        stat,
    input  logic [2:0]       s_mode,
    input  logic [IDX_W-1:0] s_position,
    input  logic [FLD_W-1:0] s_entry_id,
    input  logic [FLD_W-1:0] s_entry_duration,
    input  logic [FLD_W-1:0] s_entry_price,
    input  logic [FLD_W-1:0] s_entry_durability,
    output logic [1:0]       m_status,
    output logic [IDX_W-1:0] m_found_index,
    output logic [CNT_W-1:0] m_count,
    output logic [FLD_W-1:0] m_read_id,
    output logic [FLD_W-1:0] m_read_duration,
    output logic [FLD_W-1:0] m_read_price,
    output logic [FLD_W-1:0] m_read_durability
);

    logic [2:0]       mode_reg;
    logic [IDX_W-1:0] pos_reg;
    orl_rec_t         item_reg;
    orl_rec_t         store_reg [DEPTH];
    orl_rec_t         store_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;

    logic [1:0]       status_reg;
    logic [IDX_W-1:0] found_reg;
    logic [CNT_W-1:0] cnt_out_reg;
    orl_rec_t         rd_out_reg;

    logic [1:0]       status_c;
    logic [IDX_W-1:0] found_c;
    orl_rec_t         rd_out_c;

    logic [IDX_W-1:0] rd_addr;
    orl_rec_t         rd_rec;
    logic [CNT_W-1:0] pos_ext;
    logic             full;
    logic             idx_live;
    logic             id_hit;
    logic             do_ins;
    logic             do_del;
    logic             do_wr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] del_addr;

    // single read port: position for a read, scan pointer otherwise
    assign rd_addr  = (mode_reg == MODE_READ) ? pos_reg : idx_reg[IDX_W-1:0];
    assign rd_rec   = store_reg[rd_addr];
    assign pos_ext  = CNT_W'(pos_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign idx_live = (idx_reg < count_reg);
    assign id_hit   = idx_live && (rd_rec.id == item_reg.id);
    assign del_addr = (mode_reg == MODE_PURGE) ? idx_reg[IDX_W-1:0] : pos_reg;

    assign stat.scan_op   = (mode_reg == MODE_SEARCH) || (mode_reg == MODE_PURGE);
    assign stat.scan_done = (mode_reg == MODE_SEARCH) ? (!idx_live || id_hit) : !idx_live;

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_wr      = 1'b0;
        wr_addr    = pos_reg;
        status_c   = ST_OK;
        found_c    = '0;
        rd_out_c   = '0;

        if (cmd.step) begin
            if ((mode_reg == MODE_PURGE) && (rd_rec.durability == '0)) begin
                do_del     = 1'b1;
                count_next = count_reg - 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.commit) begin
            case (mode_reg)
                MODE_CLEAR: begin
                    count_next = '0;
                end
                MODE_INSERT: begin
                    if (full) begin
                        status_c = ST_FULL;
                    end else if (pos_ext > count_reg) begin
                        status_c = ST_RANGE;
                    end else begin
                        do_ins     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_APPEND: begin
                    if (full) begin
                        status_c = ST_FULL;
                    end else begin
                        do_wr      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_OVERWRITE: begin
                    if (pos_ext >= count_reg) begin
                        status_c = ST_RANGE;
                    end else begin
                        do_wr = 1'b1;
                    end
                end
                MODE_DELETE: begin
                    if (pos_ext >= count_reg) begin
                        status_c = ST_RANGE;
                    end else begin
                        do_del     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                MODE_SEARCH: begin
                    if (id_hit) begin
                        found_c = idx_reg[IDX_W-1:0];
                    end else begin
                        status_c = ST_MISS;
                    end
                end
                MODE_READ: begin
                    if (pos_ext >= count_reg) begin
                        status_c = ST_RANGE;
                    end else begin
                        rd_out_c = rd_rec;
                    end
                end
                default: begin
                    status_c = ST_OK;
                end
            endcase
        end
    end

    // shift chain: each entry takes its lower or upper neighbor or the new item
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            store_next[k] = store_reg[k];
            if (do_ins) begin
                if (IDX_W'(k) == pos_reg) begin
                    store_next[k] = item_reg;
                end else if (IDX_W'(k) > pos_reg) begin
                    store_next[k] = store_reg[(k == 0) ? 0 : k - 1];
                end
            end else if (do_del) begin
                if (IDX_W'(k) >= del_addr) begin
                    store_next[k] = store_reg[(k == DEPTH - 1) ? k : k + 1];
                end
            end else if (do_wr) begin
                if (IDX_W'(k) == wr_addr) begin
                    store_next[k] = item_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DEPTH; k++) begin
            store_reg[k] <= store_next[k];
        end
        if (cmd.load) begin
            mode_reg <= s_mode;
            pos_reg  <= s_position;
            item_reg <= '{id: s_entry_id, duration: s_entry_duration,
                          price: s_entry_price, durability: s_entry_durability};
        end
        if (cmd.commit) begin
            status_reg  <= status_c;
            found_reg   <= found_c;
            cnt_out_reg <= count_next;
            rd_out_reg  <= rd_out_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= cmd.load ? '0 : idx_next;
        end
    end

    assign m_status          = status_reg;
    assign m_found_index     = found_reg;
    assign m_count           = cnt_out_reg;
    assign m_read_id         = rd_out_reg.id;
    assign m_read_duration   = rd_out_reg.duration;
    assign m_read_price      = rd_out_reg.price;
    assign m_read_durability = rd_out_reg.durability;

endmodule

>>> sv/ordered_record_list.sv
// top level of the ordered record list: controller, datapath and checks
// operation: a transaction is latched on acceptance and committed once the output
//   register is free; search first scans up to a hit, purge scans every entry
// throughput: no new transaction is accepted until the previous one has committed;
//   the scan walks the record registers one entry a cycle through one read port
// reset: synchronous active-low aresetn empties the list and the controller;
//   record contents are not cleared
`timescale 1ns / 1ps

module ordered_record_list import orl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_mode,
    input  logic [IDX_W-1:0] s_position,
    input  logic [FLD_W-1:0] s_entry_id,
    input  logic [FLD_W-1:0] s_entry_duration,
    input  logic [FLD_W-1:0] s_entry_price,
    input  logic [FLD_W-1:0] s_entry_durability,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [IDX_W-1:0] m_found_index,
    output logic [CNT_W-1:0] m_count,
    output logic [FLD_W-1:0] m_read_id,
    output logic [FLD_W-1:0] m_read_duration,
    output logic [FLD_W-1:0] m_read_price,
    output logic [FLD_W-1:0] m_read_durability
);

    // command and status between controller and datapath
    orl_cmd_t  cmd;
    orl_stat_t stat;

    // controller: accepts a transaction in idle, steps scans, commits the
    // result once the output register is free or being drained
    orl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: latched request, record shift chain, count, scan pointer
    // and the registered result fields
    orl_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_mode             (s_mode),
        .s_position         (s_position),
        .s_entry_id         (s_entry_id),
        .s_entry_duration   (s_entry_duration),
        .s_entry_price      (s_entry_price),
        .s_entry_durability (s_entry_durability),
        .m_status           (m_status),
        .m_found_index      (m_found_index),
        .m_count            (m_count),
        .m_read_id          (m_read_id),
        .m_read_duration    (m_read_duration),
        .m_read_price       (m_read_price),
        .m_read_durability  (m_read_durability)
    );

`ifndef SYNTH
    // a transaction is worked on alone: no second accept right after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous transaction in flight");

    // count never exceeds the list depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_count <= CNT_W'(DEPTH)))
        else $error("result count above depth");

    // a found index is only reported with an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_found_index != '0)) |-> (m_status == ST_OK))
        else $error("found index set on failed transaction");

    // a commit never happens while the controller is idle
    a_commit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !s_ready)
        else $error("commit issued while idle");
`endif

endmodule
